// ===== rtl/core/bloom_filter_insert_query_assert.svh =====
// Assertion macros used by the top RTL file; clk and rst_n are taken from the
// module that uses them.
`ifndef BLOOM_FILTER_INSERT_QUERY_ASSERT_SVH
`define BLOOM_FILTER_INSERT_QUERY_ASSERT_SVH

`ifndef ASSERT_OFF
`define BFIQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfiq: same-cycle check failed");
`define BFIQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfiq: next-cycle check failed");
`else
`define BFIQ_ASSERT_IMP(label, ante, cons)
`define BFIQ_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/bfiq_pkg.sv =====
package bfiq_pkg;

  localparam int KEY_W         = 64;
  localparam int LEN_W         = 4;
  localparam int NUM_HASHES_W  = 5;
  localparam int FILTER_BITS_W = 15;
  localparam int HASH_W        = 32;

  localparam int MAX_BITS_DEF  = 16384;
  localparam int MAX_HASHES    = 16;
  localparam int MAX_KEY_BYTES = 8;

  localparam logic [HASH_W-1:0] HASH_SEED = 32'hbc9f1d34;
  localparam logic [HASH_W-1:0] MM_MUL    = 32'h5bd1e995;
  localparam int DELTA_ROT = 17;

  // store word: one RAM row holds this many filter bits
  localparam int WORD_BITS = 32;
  localparam int BIT_IDX_W = $clog2(WORD_BITS);

  localparam logic [NUM_HASHES_W-1:0]  NUM_HASHES_RST  = 5'd7;
  localparam logic [FILTER_BITS_W-1:0] FILTER_BITS_RST = 15'd10240;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic {
    REG_NUM_HASHES  = 1'b0,
    REG_FILTER_BITS = 1'b1
  } reg_idx_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
    logic [LEN_W-1:0] len;
  } hash_req_t;

  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] hash;
  } hash_rsp_t;

endpackage

// ===== rtl/core/bfiq_ram.sv =====
module bfiq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/bfiq_hash.sv =====
module bfiq_hash (
  input  logic                clk,
  input  logic                rst_n,
  input  bfiq_pkg::hash_req_t req,
  output bfiq_pkg::hash_rsp_t rsp
);

  import bfiq_pkg::*;

  typedef enum logic [8:0] {
    H_IDLE = 9'b000000001,
    H_K1   = 9'b000000010,
    H_K2   = 9'b000000100,
    H_HM   = 9'b000001000,
    H_HX   = 9'b000010000,
    H_TM   = 9'b000100000,
    H_TX   = 9'b001000000,
    H_F1   = 9'b010000000,
    H_F2   = 9'b100000000
  } hstate_t;

  hstate_t state_r, state_nxt;

  logic [KEY_W-1:0]  key_r;
  logic [1:0]        nblk_r;
  logic [1:0]        rest_r;
  logic              blk_r, blk_nxt;
  logic [HASH_W-1:0] h_r, h_nxt;
  logic [HASH_W-1:0] k_r;
  logic [HASH_W-1:0] prod_r;
  logic [HASH_W-1:0] mul_in;
  logic [HASH_W-1:0] mul_out;
  logic [HASH_W-1:0] blk_word;
  logic [HASH_W-1:0] tail_word;
  logic [HASH_W-1:0] tail_mask;
  logic              last_blk;

  assign blk_word  = blk_r ? key_r[63:32] : key_r[31:0];

  always_comb begin
    unique case (rest_r)
      2'd3:    tail_mask = 32'h00ff_ffff;
      2'd2:    tail_mask = 32'h0000_ffff;
      default: tail_mask = 32'h0000_00ff;
    endcase
  end

  // the tail can only follow zero or one full block
  assign tail_word = (nblk_r[0] ? key_r[63:32] : key_r[31:0]) & tail_mask;
  assign last_blk  = ({1'b0, blk_r} + 2'd1) == nblk_r;

  // one shared multiplier by the mixing constant, registered every cycle
  always_comb begin
    unique case (state_r)
      H_K1:    mul_in = blk_word;
      H_K2:    mul_in = prod_r ^ (prod_r >> 24);
      H_HM:    mul_in = h_r;
      H_TM:    mul_in = h_r ^ tail_word;
      H_F1:    mul_in = h_r ^ (h_r >> 13);
      default: mul_in = '0;
    endcase
  end

  assign mul_out = mul_in * MM_MUL;

  always_comb begin
    state_nxt = state_r;
    h_nxt     = h_r;
    blk_nxt   = blk_r;
    unique case (state_r)
      H_IDLE: begin
        if (req.start) begin
          h_nxt   = HASH_SEED ^ HASH_W'(req.len);
          blk_nxt = 1'b0;
          priority if (req.len[3:2] != 2'd0) state_nxt = H_K1;
          else if (req.len[1:0] != 2'd0)     state_nxt = H_TM;
          else                               state_nxt = H_F1;
        end
      end
      H_K1: state_nxt = H_K2;
      H_K2: state_nxt = H_HM;
      H_HM: state_nxt = H_HX;
      H_HX: begin
        h_nxt   = prod_r ^ k_r;
        blk_nxt = ~blk_r;
        priority if (!last_blk)    state_nxt = H_K1;
        else if (rest_r != 2'd0)   state_nxt = H_TM;
        else                       state_nxt = H_F1;
      end
      H_TM: state_nxt = H_TX;
      H_TX: begin
        h_nxt     = prod_r;
        state_nxt = H_F1;
      end
      H_F1: state_nxt = H_F2;
      H_F2: state_nxt = H_IDLE;
      default: state_nxt = H_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r    <= h_nxt;
    blk_r  <= blk_nxt;
    prod_r <= mul_out;
    if (state_r == H_HM) begin
      k_r <= prod_r;
    end
    if (state_r == H_IDLE && req.start) begin
      key_r  <= req.key;
      nblk_r <= req.len[3:2];
      rest_r <= req.len[1:0];
    end
  end

  assign rsp.done = (state_r == H_F2);
  assign rsp.hash = prod_r ^ (prod_r >> 15);

endmodule

// ===== rtl/core/bloom_filter_insert_query.sv =====
// The key is hashed first (the hash steps depend on key length), then each of the k effective
// probes runs the 4-bit-per-cycle remainder unit, one store read and one check that writes
// the row back on an insert. One item is in flight: a new word is taken only once the
// previous result has been loaded into the output register.
// After reset the store is cleared one 32-bit row per cycle, (MAX_BITS+31)/32
// rows (512 by default), with in_stall high; registers reset to 7 and 10240.
`include "bloom_filter_insert_query_assert.svh"

module bloom_filter_insert_query #(
  parameter int MAX_BITS = bfiq_pkg::MAX_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [bfiq_pkg::KEY_W-1:0]     in_key,
  input  logic [bfiq_pkg::LEN_W-1:0]     in_key_length,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_present,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bfiq_pkg::PADDR_W-1:0]   paddr,
  input  logic [bfiq_pkg::PDATA_W-1:0]   pwdata,
  output logic [bfiq_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  import bfiq_pkg::*;

  localparam int DEPTH     = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIV_STEPS = 4;
  localparam int DIV_CYC   = HASH_W / DIV_STEPS;
  localparam int DCNT_W    = $clog2(DIV_CYC);

  typedef enum logic [6:0] {
    ST_CLR  = 7'b0000001,
    ST_IDLE = 7'b0000010,
    ST_HASH = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_RD   = 7'b0010000,
    ST_CHK  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [NUM_HASHES_W-1:0]  cfg_num_hashes_r;
  logic [FILTER_BITS_W-1:0] cfg_filter_bits_r;
  logic [NUM_HASHES_W-1:0]  k_eff;
  logic [FILTER_BITS_W-1:0] fb_eff;
  logic                     cfg_wr;
  reg_idx_t                 cfg_idx;

  logic              in_acc;
  logic [LEN_W-1:0]  len_sat;
  op_t               op_r;
  logic              hit_r;
  logic [HASH_W-1:0] h_r;
  logic [HASH_W-1:0] delta_r;
  logic [NUM_HASHES_W-1:0] probe_cnt_r;
  logic              last_probe;

  logic [HASH_W-1:0]        div_q_r, div_q_nxt;
  logic [FILTER_BITS_W-1:0] rem_r, rem_nxt;
  logic [DCNT_W-1:0]        div_cnt_r;

  logic [ADDR_W-1:0]    clr_addr_r;
  logic [ADDR_W-1:0]    pos_addr;
  logic                 ram_we;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  logic                 probe_bit;

  logic out_load;
  logic out_valid_r;
  logic out_present_r;

  hash_req_t hreq;
  hash_rsp_t hrsp;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_num_hashes_r  <= NUM_HASHES_RST;
      cfg_filter_bits_r <= FILTER_BITS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_NUM_HASHES:  cfg_num_hashes_r  <= pwdata[NUM_HASHES_W-1:0];
        REG_FILTER_BITS: cfg_filter_bits_r <= pwdata[FILTER_BITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_NUM_HASHES:  prdata = PDATA_W'(cfg_num_hashes_r);
      REG_FILTER_BITS: prdata = PDATA_W'(cfg_filter_bits_r);
      default:         prdata = '0;
    endcase
  end

  // clamp to the built store, hash limit and key length; a zero filter size becomes one
  always_comb begin
    priority if (32'(cfg_num_hashes_r) > MAX_HASHES) k_eff = NUM_HASHES_W'(MAX_HASHES);
    else                                              k_eff = cfg_num_hashes_r;
    priority if (32'(cfg_filter_bits_r) > MAX_BITS) fb_eff = FILTER_BITS_W'(MAX_BITS);
    else if (cfg_filter_bits_r == '0)               fb_eff = FILTER_BITS_W'(1);
    else                                            fb_eff = cfg_filter_bits_r;
    priority if (32'(in_key_length) > MAX_KEY_BYTES) len_sat = LEN_W'(MAX_KEY_BYTES);
    else                                              len_sat = in_key_length;
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign hreq.start = in_acc;
  assign hreq.key   = in_key;
  assign hreq.len   = len_sat;

  bfiq_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hreq),
    .rsp   (hrsp)
  );

  // restoring remainder, four quotient bits per cycle
  always_comb begin
    logic [FILTER_BITS_W:0] t;
    rem_nxt   = rem_r;
    div_q_nxt = div_q_r;
    for (int j = 0; j < DIV_STEPS; j++) begin
      t         = {rem_nxt, div_q_nxt[HASH_W-1]};
      div_q_nxt = div_q_nxt << 1;
      if (t >= {1'b0, fb_eff}) begin
        rem_nxt = FILTER_BITS_W'(t - {1'b0, fb_eff});
      end else begin
        rem_nxt = t[FILTER_BITS_W-1:0];
      end
    end
  end

  assign pos_addr   = ADDR_W'(rem_r >> BIT_IDX_W);
  assign probe_bit  = ram_rdata[rem_r[BIT_IDX_W-1:0]];
  assign last_probe = (probe_cnt_r == k_eff - NUM_HASHES_W'(1));
  assign out_load   = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:  if (clr_addr_r == ADDR_W'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: if (in_acc) state_nxt = ST_HASH;
      ST_HASH: begin
        if (hrsp.done) begin
          state_nxt = (k_eff == '0) ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV:  if (div_cnt_r == DCNT_W'(DIV_CYC - 1)) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_CHK;
      ST_CHK:  state_nxt = last_probe ? ST_DONE : ST_DIV;
      ST_DONE: if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= op_t'(in_operation);
      hit_r <= 1'b1;
    end
    if (state_r == ST_HASH && hrsp.done) begin
      h_r         <= hrsp.hash;
      delta_r     <= (hrsp.hash >> DELTA_ROT) | (hrsp.hash << (HASH_W - DELTA_ROT));
      div_q_r     <= hrsp.hash;
      rem_r       <= '0;
      div_cnt_r   <= '0;
      probe_cnt_r <= '0;
    end
    if (state_r == ST_DIV) begin
      div_q_r   <= div_q_nxt;
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + DCNT_W'(1);
    end
    if (state_r == ST_CHK) begin
      if (op_r == OP_QUERY && !probe_bit) begin
        hit_r <= 1'b0;
      end
      // advance to the next probe; the hash wraps at 32 bits
      h_r         <= h_r + delta_r;
      div_q_r     <= h_r + delta_r;
      rem_r       <= '0;
      div_cnt_r   <= '0;
      probe_cnt_r <= probe_cnt_r + NUM_HASHES_W'(1);
    end
  end

  // bit store of 32-bit rows; one row is read per probe and written back with the bit set on an insert
  assign ram_re    = (state_r == ST_RD);
  assign ram_we    = (state_r == ST_CLR) || (state_r == ST_CHK && op_r == OP_INSERT);
  assign ram_waddr = (state_r == ST_CLR) ? clr_addr_r : pos_addr;
  assign ram_wdata = (state_r == ST_CLR) ? '0
                   : (ram_rdata | (WORD_BITS'(1) << rem_r[BIT_IDX_W-1:0]));

  bfiq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (pos_addr),
    .rdata (ram_rdata)
  );

  // result word register; hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      priority if (out_load)   out_valid_r <= 1'b1;
      else if (!out_stall)     out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_present_r <= (op_r == OP_QUERY) && hit_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_present = out_present_r;

  `BFIQ_ASSERT_NXT(a_result_held, out_valid && out_stall, out_valid && $stable(out_present))
  `BFIQ_ASSERT_IMP(a_probe_in_range, (state_r == ST_RD), (rem_r < fb_eff))
  `BFIQ_ASSERT_IMP(a_probe_count,
                   (state_r == ST_DIV) || (state_r == ST_RD) || (state_r == ST_CHK),
                   (probe_cnt_r < k_eff))
  `BFIQ_ASSERT_NXT(a_insert_absent, out_load && (op_r == OP_INSERT), out_valid && !out_present)

endmodule
